FILE: rtl/r8fft_pkg.sv
// Shared constants, types, twiddle tables and helpers for the radix-8 FFT.
package r8fft_pkg;

    localparam int POINTS      = 64;
    localparam int LOG2_POINTS = 6;
    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 24;
    localparam int DP_BITS     = 32;
    localparam int PASSES      = LOG2_POINTS / 3;
    localparam int J_BITS      = LOG2_POINTS - 3;
    localparam int ADDR_BITS   = LOG2_POINTS + 1;
    localparam int TW_BITS     = 17;
    localparam int SQRT_HALF_Q15 = 23170;
    localparam longint ONE_Q30    = 64'sd1073741824;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;

    typedef logic signed [DP_BITS-1:0] dp_t;
    typedef logic signed [ACC_BITS-1:0] acc_t;
    typedef logic signed [TW_BITS-1:0] tw_t;
    typedef tw_t rom_t [POINTS];

    typedef struct packed {
        dp_t re;
        dp_t im;
    } cplx_t;

    // Q30 clamp and round half up to Q15
    function automatic longint q30_to_q15(input longint v);
        longint c;
        begin
            c = v;
            if (c < 0) c = 0;
            if (c > ONE_Q30) c = ONE_Q30;
            return (c + 16384) >>> 15;
        end
    endfunction

    // Long division of a non-negative value, used only while building the tables
    function automatic longint udiv_small(input longint num, input int den);
        longint quo, remd;
        begin
            quo  = 0;
            remd = 0;
            for (int i = 62; i >= 0; i--) begin
                remd = (remd <<< 1) | ((num >>> i) & 64'sd1);
                quo  = quo <<< 1;
                if (remd >= longint'(den)) begin
                    remd = remd - longint'(den);
                    quo  = quo | 64'sd1;
                end
            end
            return quo;
        end
    endfunction

    // Twiddle table: Taylor series on the first quadrant, mirrored by quadrant
    function automatic rom_t tw_table(input bit im_sel);
        rom_t   tab;
        longint phi, s, c, t, cq, sq, ct, st;
        int     q, rem;
        begin
            for (int m = 0; m < POINTS; m++) begin
                q   = (m >> (LOG2_POINTS - 2)) & 3;
                rem = m & (POINTS / 4 - 1);
                phi = (TWO_PI_Q30 * longint'(rem)) >>> LOG2_POINTS;
                s = 0;
                c = ONE_Q30;
                t = ONE_Q30;
                for (int n = 1; n <= 20; n++) begin
                    t = udiv_small((t * phi) >>> 30, n);
                    case (n & 3)
                        1: s = s + t;
                        2: c = c - t;
                        3: s = s - t;
                        default: c = c + t;
                    endcase
                end
                cq = q30_to_q15(c);
                sq = q30_to_q15(s);
                case (q)
                    0: begin ct = cq;  st = sq;  end
                    1: begin ct = -sq; st = cq;  end
                    2: begin ct = -cq; st = -sq; end
                    default: begin ct = sq; st = -cq; end
                endcase
                tab[m] = im_sel ? TW_BITS'(-st) : TW_BITS'(ct);
            end
            return tab;
        end
    endfunction

    localparam rom_t TW_RE = tw_table(1'b0);
    localparam rom_t TW_IM = tw_table(1'b1);

    // Saturate a datapath value to the bank word width
    function automatic acc_t sat_acc(input dp_t v);
        begin
            if (v > dp_t'((1 <<< (ACC_BITS - 1)) - 1))
                return acc_t'((1 <<< (ACC_BITS - 1)) - 1);
            else if (v < -dp_t'(1 <<< (ACC_BITS - 1)))
                return acc_t'(-(1 <<< (ACC_BITS - 1)));
            else
                return acc_t'(v);
        end
    endfunction

endpackage

FILE: rtl/r8fft_bank.sv
// Two sample banks in one synchronous RAM, one write and one registered read port.
module r8fft_bank (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [r8fft_pkg::ADDR_BITS-1:0] wr_addr,
    input  logic [2*r8fft_pkg::ACC_BITS-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [r8fft_pkg::ADDR_BITS-1:0] rd_addr,
    output logic [2*r8fft_pkg::ACC_BITS-1:0] rd_data
);

    logic [2*r8fft_pkg::ACC_BITS-1:0] mem [2*r8fft_pkg::POINTS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/r8fft_cmul.sv
// Twiddle multiply: ROM lookup, registered products, floor and combine.
module r8fft_cmul (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [2:0]                        in_r,
    input  logic [r8fft_pkg::LOG2_POINTS-1:0] in_m,
    input  logic [2*r8fft_pkg::ACC_BITS-1:0]  in_data,
    output logic                              out_valid,
    output logic [2:0]                        out_r,
    output r8fft_pkg::cplx_t                  out_x
);

    localparam int P_BITS = r8fft_pkg::ACC_BITS + r8fft_pkg::TW_BITS;

    r8fft_pkg::acc_t      xr, xi;
    r8fft_pkg::tw_t       wr, wi;
    logic signed [P_BITS-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic                 valid_reg;
    logic [2:0]           r_reg;

    assign xr = r8fft_pkg::acc_t'(in_data[2*r8fft_pkg::ACC_BITS-1:r8fft_pkg::ACC_BITS]);
    assign xi = r8fft_pkg::acc_t'(in_data[r8fft_pkg::ACC_BITS-1:0]);
    assign wr = r8fft_pkg::TW_RE[in_m];
    assign wi = r8fft_pkg::TW_IM[in_m];

    // product registers
    always_ff @(posedge clk)
    begin
        p_rr_reg <= P_BITS'(xr) * P_BITS'(wr);
        p_ii_reg <= P_BITS'(xi) * P_BITS'(wi);
        p_ri_reg <= P_BITS'(xr) * P_BITS'(wi);
        p_ir_reg <= P_BITS'(xi) * P_BITS'(wr);
        r_reg    <= in_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // floor by 2^15 and combine
    assign out_x.re = r8fft_pkg::dp_t'($signed(p_rr_reg[P_BITS-1:15]))
                    - r8fft_pkg::dp_t'($signed(p_ii_reg[P_BITS-1:15]));
    assign out_x.im = r8fft_pkg::dp_t'($signed(p_ri_reg[P_BITS-1:15]))
                    + r8fft_pkg::dp_t'($signed(p_ir_reg[P_BITS-1:15]));
    assign out_valid = valid_reg;
    assign out_r     = r_reg;

endmodule

FILE: rtl/r8fft_bfly.sv
// Eight-point butterfly with registered outputs.
module r8fft_bfly (
    input  logic                    clk,
    input  logic                    calc_en,
    input  r8fft_pkg::cplx_t [7:0]  x,
    output r8fft_pkg::cplx_t [7:0]  y
);

    localparam int H_BITS = 48;

    r8fft_pkg::cplx_t [3:0] a, b, bt;
    r8fft_pkg::cplx_t [7:0] y_next, y_reg;
    logic signed [H_BITS-1:0] h1r, h1i, h3r, h3i;

    // Q1.15 multiply by sqrt2/2, floored
    function automatic r8fft_pkg::dp_t mul_half(input logic signed [H_BITS-1:0] p);
        begin
            return r8fft_pkg::dp_t'($signed(p[H_BITS-2:15]));
        end
    endfunction

    // first layer and odd-branch rotation
    always_comb
    begin
        for (int r = 0; r < 4; r++) begin
            a[r].re = x[r].re + x[r+4].re;
            a[r].im = x[r].im + x[r+4].im;
            b[r].re = x[r].re - x[r+4].re;
            b[r].im = x[r].im - x[r+4].im;
        end
        h1r = H_BITS'(b[1].re) * H_BITS'(r8fft_pkg::SQRT_HALF_Q15);
        h1i = H_BITS'(b[1].im) * H_BITS'(r8fft_pkg::SQRT_HALF_Q15);
        h3r = H_BITS'(b[3].re) * H_BITS'(r8fft_pkg::SQRT_HALF_Q15);
        h3i = H_BITS'(b[3].im) * H_BITS'(r8fft_pkg::SQRT_HALF_Q15);
        bt[0]    = b[0];
        bt[1].re = mul_half(h1r) + mul_half(h1i);
        bt[1].im = mul_half(h1i) - mul_half(h1r);
        bt[2].re = b[2].im;
        bt[2].im = -b[2].re;
        bt[3].re = mul_half(h3i) - mul_half(h3r);
        bt[3].im = -mul_half(h3r) - mul_half(h3i);
    end

    // two four-point DFTs, even and odd outputs
    always_comb
    begin
        r8fft_pkg::dp_t p0r, p0i, p1r, p1i, q0r, q0i, q1r, q1i;
        r8fft_pkg::cplx_t [3:0] c;
        for (int base = 0; base < 2; base++) begin
            c   = (base == 0) ? a : bt;
            p0r = c[0].re + c[2].re;  p0i = c[0].im + c[2].im;
            p1r = c[0].re - c[2].re;  p1i = c[0].im - c[2].im;
            q0r = c[1].re + c[3].re;  q0i = c[1].im + c[3].im;
            q1r = c[1].re - c[3].re;  q1i = c[1].im - c[3].im;
            y_next[base].re   = p0r + q0r;  y_next[base].im   = p0i + q0i;
            y_next[base+4].re = p0r - q0r;  y_next[base+4].im = p0i - q0i;
            y_next[base+2].re = p1r + q1i;  y_next[base+2].im = p1i - q1r;
            y_next[base+6].re = p1r - q1i;  y_next[base+6].im = p1i + q1r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_en)
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

FILE: rtl/radix8_fft_top.sv
// Radix-8 Stockham FFT: load, pass control, readout over a two-bank RAM.
// Loading takes one sample per cycle while start is high; the last sample starts the transform and raises busy.
// Each pass does POINTS/8 butterflies, each a read phase, a butterfly step and a write phase.
// Bins strobe one per cycle; the receiver cannot stall.
// Reset returns to loading with an empty frame; RAM contents are not cleared.
module radix8_fft_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [r8fft_pkg::SAMPLE_BITS-1:0] sample_re,
    input  logic signed [r8fft_pkg::SAMPLE_BITS-1:0] sample_im,
    output logic                                bin_valid,
    output logic signed [r8fft_pkg::ACC_BITS-1:0]    bin_re,
    output logic signed [r8fft_pkg::ACC_BITS-1:0]    bin_im,
    output logic                                last_bin
);

    localparam int LG = r8fft_pkg::LOG2_POINTS;
    localparam int JB = r8fft_pkg::J_BITS;
    localparam int AW = r8fft_pkg::ADDR_BITS;
    localparam int DW = 2 * r8fft_pkg::ACC_BITS;
    localparam int PB = (r8fft_pkg::PASSES > 1) ? $clog2(r8fft_pkg::PASSES) : 1;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [3:0] READ_LAST = 4'd9;

    logic [2:0]    state_reg, state_next;
    logic [LG-1:0] load_cnt_reg, load_cnt_next;
    logic [PB-1:0] pass_reg, pass_next;
    logic [JB-1:0] j_reg, j_next;
    logic [3:0]    step_reg, step_next;
    logic [LG-1:0] out_idx_reg, out_idx_next;
    logic          iss_v_reg, out_v_reg, out_last_reg;
    logic [2:0]    iss_r_reg;
    logic [LG-1:0] iss_m_reg;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] wr_data, rd_data;

    logic          x_valid;
    logic [2:0]    x_r;
    r8fft_pkg::cplx_t        x_val;
    r8fft_pkg::cplx_t [7:0]  x_reg, y;

    logic [LG-1:0] span_mask, k, rk, m_idx, base, di, r_span;
    logic [2:0]    r_cur;
    logic [4:0]    sh3;
    logic          src_bank;

    r8fft_pkg::acc_t s_re, s_im;

    // pass geometry: span = 8^pass
    assign sh3       = 5'(3 * pass_reg);
    assign span_mask = LG'((1 << sh3) - 1);
    assign k         = LG'(j_reg) & span_mask;
    assign r_cur     = step_reg[2:0];
    assign rk        = LG'(r_cur) * k;
    assign m_idx     = LG'(rk << (5'(LG - 3) - sh3));
    assign base      = LG'((LG'(j_reg) >> sh3) << (sh3 + 5'd3)) | k;
    assign r_span    = LG'(LG'(r_cur) << sh3);
    assign di        = base + r_span;
    assign src_bank  = pass_reg[0];

    // input sample, sign extended
    assign s_re = r8fft_pkg::acc_t'(sample_re);
    assign s_im = r8fft_pkg::acc_t'(sample_im);

    // RAM port muxing
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {1'b0, load_cnt_reg};
        wr_data = {s_re, s_im};
        rd_en   = 1'b0;
        rd_addr = {src_bank, r_cur, j_reg};
        unique case (state_reg)
            ST_LOAD:
            begin
                wr_en = start;
            end
            ST_READ:
            begin
                rd_en = (step_reg < 4'd8);
            end
            ST_WRITE:
            begin
                wr_en   = 1'b1;
                wr_addr = {~src_bank, di};
                wr_data = {r8fft_pkg::sat_acc(y[r_cur].re), r8fft_pkg::sat_acc(y[r_cur].im)};
            end
            ST_OUT:
            begin
                rd_en   = 1'b1;
                rd_addr = {src_bank, out_idx_reg};
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        pass_next     = pass_reg;
        j_next        = j_reg;
        step_next     = step_reg;
        out_idx_next  = out_idx_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (start) begin
                    load_cnt_next = load_cnt_reg + 1'b1;
                    if (load_cnt_reg == LG'(r8fft_pkg::POINTS - 1)) begin
                        state_next = ST_READ;
                        pass_next  = '0;
                        j_next     = '0;
                        step_next  = '0;
                    end
                end
            end
            ST_READ:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == READ_LAST)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                step_next  = '0;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd7) begin
                    step_next = '0;
                    j_next    = j_reg + 1'b1;
                    if (j_reg == JB'(r8fft_pkg::POINTS / 8 - 1)) begin
                        if (pass_reg == PB'(r8fft_pkg::PASSES - 1)) begin
                            pass_next    = PB'(r8fft_pkg::PASSES);
                            out_idx_next = '0;
                            state_next   = ST_OUT;
                        end else begin
                            pass_next  = pass_reg + 1'b1;
                            state_next = ST_READ;
                        end
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_OUT:
            begin
                out_idx_next = out_idx_reg + 1'b1;
                if (out_idx_reg == LG'(r8fft_pkg::POINTS - 1)) begin
                    pass_next  = '0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            pass_reg     <= '0;
            j_reg        <= '0;
            step_reg     <= '0;
            out_idx_reg  <= '0;
            iss_v_reg    <= 1'b0;
            out_v_reg    <= 1'b0;
            out_last_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            pass_reg     <= pass_next;
            j_reg        <= j_next;
            step_reg     <= step_next;
            out_idx_reg  <= out_idx_next;
            iss_v_reg    <= (state_reg == ST_READ) && (step_reg < 4'd8);
            out_v_reg    <= (state_reg == ST_OUT);
            out_last_reg <= (state_reg == ST_OUT)
                         && (out_idx_reg == LG'(r8fft_pkg::POINTS - 1));
        end
    end

    // read-side tags aligned with RAM data
    always_ff @(posedge clk)
    begin
        iss_r_reg <= r_cur;
        iss_m_reg <= m_idx;
    end

    // twiddled butterfly inputs
    always_ff @(posedge clk)
    begin
        if (x_valid)
            x_reg[x_r] <= x_val;
    end

    r8fft_bank u_bank (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    r8fft_cmul u_cmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (iss_v_reg),
        .in_r      (iss_r_reg),
        .in_m      (iss_m_reg),
        .in_data   (rd_data),
        .out_valid (x_valid),
        .out_r     (x_r),
        .out_x     (x_val)
    );

    r8fft_bfly u_bfly (
        .clk     (clk),
        .calc_en (state_reg == ST_CALC),
        .x       (x_reg),
        .y       (y)
    );

    assign busy      = (state_reg != ST_LOAD);
    assign bin_valid = out_v_reg;
    assign bin_re    = rd_data[DW-1:r8fft_pkg::ACC_BITS];
    assign bin_im    = rd_data[r8fft_pkg::ACC_BITS-1:0];
    assign last_bin  = out_last_reg;

endmodule
